[hdl/fbm_pkg.sv]
// Shared types, constants and codes of the flow byte meter table.
`default_nettype none
package fbm_pkg;
  localparam int ENTRIES = 1024;
  localparam int SLOTS   = 10;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int HEAD_W  = $clog2(SLOTS);
  localparam int SADDR_W = $clog2(ENTRIES * SLOTS);
  localparam int CFG_IDX_W = 3;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  localparam logic [1:0] OP_PKT  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] ST_EXIST = 3'd0;
  localparam logic [2:0] ST_NEW   = 3'd1;
  localparam logic [2:0] ST_IGN   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_TICK  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_V4       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V4_VALID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_V6_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_V6_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_V6_VALID = 3'd4;

  typedef struct packed {
    logic [31:0] v4;
    logic        v4_valid;
    logic [63:0] v6_high;
    logic [63:0] v6_low;
    logic        v6_valid;
  } cfg_t;

  // flags: bit0 upload, bit1 ipv6
  typedef struct packed {
    logic [1:0]  flags;
    logic [63:0] high;
    logic [63:0] low;
  } key_t;

  typedef struct packed {
    logic ignore;
    key_t key;
  } cls_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pkt_len;
    logic [9:0]  entry_index;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_valid;
    logic [63:0] peer_high;
    logic [63:0] peer_low;
    logic        upload_flag;
    logic        ipv6_flag;
    logic [31:0] sum_three;
    logic [31:0] sum_five;
    logic [31:0] sum_window;
    logic [31:0] total_out;
    logic [31:0] peak_out;
  } res_t;
endpackage
`default_nettype wire

[hdl/fbm_if.sv]
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface fbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] ethertype;
  logic [63:0] src_addr_high;
  logic [63:0] src_addr_low;
  logic [63:0] dst_addr_high;
  logic [63:0] dst_addr_low;
  logic [15:0] pkt_len;
  logic [9:0]  entry_index;
  modport source (output valid, op, ethertype, src_addr_high, src_addr_low, dst_addr_high,
                  dst_addr_low, pkt_len, entry_index, input ready);
  modport sink (input valid, op, ethertype, src_addr_high, src_addr_low, dst_addr_high,
                dst_addr_low, pkt_len, entry_index, output ready);
endinterface

interface fbm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        entry_valid;
  logic [63:0] peer_high;
  logic [63:0] peer_low;
  logic        upload_flag;
  logic        ipv6_flag;
  logic [31:0] sum_three;
  logic [31:0] sum_five;
  logic [31:0] sum_window;
  logic [31:0] total_out;
  logic [31:0] peak_out;
  logic [10:0] entry_count_out;
  modport source (output valid, status, entry_valid, peer_high, peer_low, upload_flag,
                  ipv6_flag, sum_three, sum_five, sum_window, total_out, peak_out,
                  entry_count_out, input ready);
  modport sink (input valid, status, entry_valid, peer_high, peer_low, upload_flag,
                ipv6_flag, sum_three, sum_five, sum_window, total_out, peak_out,
                entry_count_out, output ready);
endinterface
`default_nettype wire

[hdl/fbm_classify.sv]
// Packet classifier: picks the peer, direction and family or marks the packet ignored.
`default_nettype none
module fbm_classify (
  input  fbm_pkg::cfg_t cfg_i,
  input  logic [15:0]   ethertype_i,
  input  logic [63:0]   src_high_i,
  input  logic [63:0]   src_low_i,
  input  logic [63:0]   dst_high_i,
  input  logic [63:0]   dst_low_i,
  output fbm_pkg::cls_t cls_o
);
  logic is4, is6, src_self, dst_self;
  logic [63:0] sh, sl, dh, dl;

  always_comb begin
    is4 = (ethertype_i == fbm_pkg::ETH_IPV4);
    is6 = (ethertype_i == fbm_pkg::ETH_IPV6);
    if (is4) begin
      sh = '0;
      dh = '0;
      sl = {32'd0, src_low_i[31:0]};
      dl = {32'd0, dst_low_i[31:0]};
      src_self = cfg_i.v4_valid && (src_low_i[31:0] == cfg_i.v4);
      dst_self = cfg_i.v4_valid && (dst_low_i[31:0] == cfg_i.v4);
    end else begin
      sh = src_high_i;
      dh = dst_high_i;
      sl = src_low_i;
      dl = dst_low_i;
      src_self = cfg_i.v6_valid && (src_high_i == cfg_i.v6_high) && (src_low_i == cfg_i.v6_low);
      dst_self = cfg_i.v6_valid && (dst_high_i == cfg_i.v6_high) && (dst_low_i == cfg_i.v6_low);
    end
    cls_o.ignore = !(is4 || is6) || (src_self == dst_self);
    cls_o.key.flags = {is6, src_self};
    cls_o.key.high  = src_self ? dh : sh;
    cls_o.key.low   = src_self ? dl : sl;
  end
endmodule
`default_nettype wire

[hdl/fbm_engine.sv]
// Table storage and the sequencer that scans, updates and reads it through one adder.
`default_nettype none
module fbm_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fbm_pkg::cmd_t               cmd_i,
  input  fbm_pkg::cls_t               cls_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fbm_pkg::res_t               res_o,
  output logic [fbm_pkg::CNT_W-1:0]   count_o
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_HIT1 = 4'd2;
  localparam logic [3:0] S_HIT2 = 4'd3;
  localparam logic [3:0] S_HIT3 = 4'd4;
  localparam logic [3:0] S_NEW  = 4'd5;
  localparam logic [3:0] S_CLR  = 4'd6;
  localparam logic [3:0] S_TK1  = 4'd7;
  localparam logic [3:0] S_TK2  = 4'd8;
  localparam logic [3:0] S_TK3  = 4'd9;
  localparam logic [3:0] S_RD1  = 4'd10;
  localparam logic [3:0] S_RD2  = 4'd11;
  localparam logic [3:0] S_RDS  = 4'd12;

  localparam int IW = fbm_pkg::IDX_W;
  localparam int CW = fbm_pkg::CNT_W;
  localparam int HW = fbm_pkg::HEAD_W;
  localparam int AW = fbm_pkg::SADDR_W;
  localparam logic [HW-1:0] LAST_SLOT = HW'(fbm_pkg::SLOTS - 1);

  logic [3:0]   state_q, state_d;
  logic [CW-1:0] count_q, count_d, scan_q, scan_d;
  logic [IW-1:0] idx_q, idx_d, cmp_q, cmp_d;
  logic          pend_q, pend_d;
  logic [HW-1:0] ptr_q, ptr_d;
  logic [HW:0]   iss_q, iss_d, acnt_q, acnt_d;
  logic [31:0]   acc_q, acc_d;
  fbm_pkg::key_t key_q, key_d;
  logic [15:0]   len_q, len_d;
  fbm_pkg::res_t res_q, res_d;
  logic          out_valid_q, out_valid_d;

  // storage
  fbm_pkg::key_t key_mem  [fbm_pkg::ENTRIES];
  logic [HW-1:0] head_mem [fbm_pkg::ENTRIES];
  logic [31:0]   tot_mem  [fbm_pkg::ENTRIES];
  logic [31:0]   peak_mem [fbm_pkg::ENTRIES];
  logic [31:0]   slot_mem [fbm_pkg::ENTRIES * fbm_pkg::SLOTS];

  fbm_pkg::key_t key_rd_q, key_wd;
  logic [HW-1:0] head_rd_q, head_wd, slot_p, slot_wp;
  logic [31:0]   tot_rd_q, peak_rd_q, slot_rd_q, tot_wd, peak_wd, slot_wd;
  logic [IW-1:0] key_ra, key_wa;
  logic          key_we, head_we, tot_we, peak_we, slot_we;
  logic [AW-1:0] slot_base, slot_ra, slot_wa;
  logic [31:0]   add_a, add_b, add_y;
  logic [HW-1:0] head_nx;

  assign slot_base = AW'(idx_q) * AW'(fbm_pkg::SLOTS);
  assign slot_ra   = AW'(slot_base + AW'(slot_p));
  assign slot_wa   = AW'(slot_base + AW'(slot_wp));
  assign key_ra    = (state_q == S_SCAN) ? scan_q[IW-1:0] : idx_q;
  assign add_y     = add_a + add_b;
  assign head_nx   = (head_rd_q == LAST_SLOT) ? '0 : HW'(head_rd_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (key_we)  key_mem[key_wa] <= key_wd;
    if (head_we) head_mem[idx_q] <= head_wd;
    if (tot_we)  tot_mem[idx_q]  <= tot_wd;
    if (peak_we) peak_mem[idx_q] <= peak_wd;
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    key_rd_q  <= key_mem[key_ra];
    head_rd_q <= head_mem[idx_q];
    tot_rd_q  <= tot_mem[idx_q];
    peak_rd_q <= peak_mem[idx_q];
    slot_rd_q <= slot_mem[slot_ra];
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign count_o     = count_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    scan_d  = scan_q;
    idx_d   = idx_q;
    cmp_d   = cmp_q;
    pend_d  = pend_q;
    ptr_d   = ptr_q;
    iss_d   = iss_q;
    acnt_d  = acnt_q;
    acc_d   = acc_q;
    key_d   = key_q;
    len_d   = len_q;
    res_d   = res_q;
    out_valid_d = out_valid_q;
    key_we  = 1'b0;
    key_wa  = idx_q;
    key_wd  = key_q;
    head_we = 1'b0;
    head_wd = head_nx;
    tot_we  = 1'b0;
    tot_wd  = add_y;
    peak_we = 1'b0;
    peak_wd = (slot_rd_q > peak_rd_q) ? slot_rd_q : peak_rd_q;
    slot_we = 1'b0;
    slot_wd = add_y;
    slot_p  = head_rd_q;
    slot_wp = head_rd_q;
    add_a   = slot_rd_q;
    add_b   = {16'd0, len_q};

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          res_d  = '0;
          key_d  = cls_i.key;
          len_d  = cmd_i.pkt_len;
          scan_d = '0;
          pend_d = 1'b0;
          idx_d  = '0;
          case (cmd_i.op)
            fbm_pkg::OP_PKT: begin
              if (cls_i.ignore) begin
                res_d.status = fbm_pkg::ST_IGN;
                out_valid_d  = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            fbm_pkg::OP_TICK: begin
              res_d.status = fbm_pkg::ST_TICK;
              if (count_q == '0) out_valid_d = 1'b1;
              else state_d = S_TK1;
            end
            fbm_pkg::OP_READ: begin
              res_d.status = fbm_pkg::ST_READ;
              idx_d = cmd_i.entry_index[IW-1:0];
              if (CW'(cmd_i.entry_index) >= count_q) out_valid_d = 1'b1;
              else state_d = S_RD1;
            end
            default: begin
              res_d.status = fbm_pkg::ST_IGN;
              out_valid_d  = 1'b1;
            end
          endcase
        end
      end
      // one key read issued per cycle, compared the cycle after
      S_SCAN: begin
        if (pend_q && (key_rd_q == key_q)) begin
          idx_d   = cmp_q;
          pend_d  = 1'b0;
          state_d = S_HIT1;
        end else if (scan_q < count_q) begin
          pend_d = 1'b1;
          cmp_d  = scan_q[IW-1:0];
          scan_d = CW'(scan_q + 1'b1);
        end else begin
          pend_d  = 1'b0;
          state_d = S_NEW;
        end
      end
      S_HIT1: state_d = S_HIT2;
      S_HIT2: begin
        add_a   = tot_rd_q;
        tot_we  = 1'b1;
        state_d = S_HIT3;
      end
      S_HIT3: begin
        slot_we = 1'b1;
        res_d.status = fbm_pkg::ST_EXIST;
        out_valid_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_NEW: begin
        if (count_q >= CW'(fbm_pkg::ENTRIES)) begin
          res_d.status = fbm_pkg::ST_FULL;
          out_valid_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          key_we  = 1'b1;
          key_wa  = count_q[IW-1:0];
          idx_d   = count_q[IW-1:0];
          acnt_d  = '0;
          state_d = S_CLR;
        end
      end
      // write head, total and peak of the new entry while sweeping its slots
      S_CLR: begin
        head_we = 1'b1;
        head_wd = '0;
        tot_we  = 1'b1;
        tot_wd  = {16'd0, len_q};
        peak_we = 1'b1;
        peak_wd = '0;
        slot_we = 1'b1;
        slot_wp = acnt_q[HW-1:0];
        slot_wd = (acnt_q == '0) ? {16'd0, len_q} : 32'd0;
        acnt_d  = (HW+1)'(acnt_q + 1'b1);
        if (acnt_q == (HW+1)'(fbm_pkg::SLOTS - 1)) begin
          count_d = CW'(count_q + 1'b1);
          res_d.status = fbm_pkg::ST_NEW;
          out_valid_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TK1: state_d = S_TK2;
      S_TK2: state_d = S_TK3;
      S_TK3: begin
        peak_we = 1'b1;
        head_we = 1'b1;
        slot_we = 1'b1;
        slot_wp = head_nx;
        slot_wd = '0;
        if (CW'(idx_q) + 1'b1 < count_q) begin
          idx_d   = IW'(idx_q + 1'b1);
          state_d = S_TK1;
        end else begin
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD1: state_d = S_RD2;
      S_RD2: begin
        ptr_d  = (head_rd_q == '0) ? LAST_SLOT : HW'(head_rd_q - 1'b1);
        iss_d  = '0;
        acnt_d = '0;
        acc_d  = '0;
        pend_d = 1'b0;
        state_d = S_RDS;
      end
      // walk back from the head, accumulate one slot per cycle
      S_RDS: begin
        slot_p = ptr_q;
        add_a  = acc_q;
        add_b  = slot_rd_q;
        if (iss_q < (HW+1)'(fbm_pkg::SLOTS)) begin
          pend_d = 1'b1;
          iss_d  = (HW+1)'(iss_q + 1'b1);
          ptr_d  = (ptr_q == '0) ? LAST_SLOT : HW'(ptr_q - 1'b1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          acc_d  = add_y;
          acnt_d = (HW+1)'(acnt_q + 1'b1);
          if (acnt_q == (HW+1)'(2)) res_d.sum_three = add_y;
          if (acnt_q == (HW+1)'(4)) res_d.sum_five  = add_y;
          if (acnt_q == (HW+1)'(fbm_pkg::SLOTS - 1)) begin
            res_d.sum_window  = add_y;
            res_d.entry_valid = 1'b1;
            res_d.peer_high   = key_rd_q.high;
            res_d.peer_low    = key_rd_q.low;
            res_d.upload_flag = key_rd_q.flags[0];
            res_d.ipv6_flag   = key_rd_q.flags[1];
            res_d.total_out   = tot_rd_q;
            res_d.peak_out    = peak_rd_q;
            out_valid_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    idx_q  <= idx_d;
    cmp_q  <= cmp_d;
    ptr_q  <= ptr_d;
    iss_q  <= iss_d;
    acnt_q <= acnt_d;
    acc_q  <= acc_d;
    key_q  <= key_d;
    len_q  <= len_d;
    res_q  <= res_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(fbm_pkg::ENTRIES)) else $error("entry count beyond table size");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE)) else $error("ready while busy");
  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_CLR && out_valid_q))
    else $error("entry count moved outside entry creation");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q <= count_q)) else $error("scan ran past entry count");
endmodule
`default_nettype wire

[hdl/flow_byte_meter_table_top.sv]
// Top level of the per-peer byte meter: channels, configuration registers, classifier, engine.
//
// Input channel in_i carries one item per transfer: op 0 counts a packet against its peer
// entry, op 1 is the one-second tick, op 2 reads one entry. Output channel out_o returns
// exactly one result per item. The user is to set local addresses via cfg_we_i / cfg_idx_i /
// cfg_data_i only while the block is idle (it is unchecked); indexes above 4 are dropped.
// Sequence from input transfer to result valid, n = entries in use:
//   ignored packet, unknown op, out-of-range read, tick on an empty table: no table access;
//   packet: a scan over the n entries, one key compared per cycle, then on a hit a total
//   and slot write, on a miss a full-table result or a key write plus a 10-slot clearing
//   sweep that creates the entry;
//   tick: per entry a head read, a slot read, then the peak/head/slot write;
//   read: head read, then one window slot summed per cycle through the shared adder.
// One item is in flight at a time: ready stays low from the input transfer until the
// result has been transferred, so a stalled receiver simply holds the block.
// Reset empties the table (entry count zero) and clears the local addresses; entry
// storage itself is not swept.
`default_nettype none
module flow_byte_meter_table_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fbm_in_if.sink                            in_i,
  fbm_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [fbm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [63:0]                       cfg_data_i
);
  fbm_pkg::cfg_t cfg_q;
  fbm_pkg::cls_t cls;
  fbm_pkg::cmd_t cmd;
  fbm_pkg::res_t res;
  logic [fbm_pkg::CNT_W-1:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbm_pkg::CFG_V4:       cfg_q.v4       <= cfg_data_i[31:0];
        fbm_pkg::CFG_V4_VALID: cfg_q.v4_valid <= cfg_data_i[0];
        fbm_pkg::CFG_V6_HIGH:  cfg_q.v6_high  <= cfg_data_i;
        fbm_pkg::CFG_V6_LOW:   cfg_q.v6_low   <= cfg_data_i;
        fbm_pkg::CFG_V6_VALID: cfg_q.v6_valid <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cmd.op          = in_i.op;
  assign cmd.pkt_len     = in_i.pkt_len;
  assign cmd.entry_index = in_i.entry_index;

  fbm_classify u_classify (
    .cfg_i       (cfg_q),
    .ethertype_i (in_i.ethertype),
    .src_high_i  (in_i.src_addr_high),
    .src_low_i   (in_i.src_addr_low),
    .dst_high_i  (in_i.dst_addr_high),
    .dst_low_i   (in_i.dst_addr_low),
    .cls_o       (cls)
  );

  fbm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .cmd_i       (cmd),
    .cls_i       (cls),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res),
    .count_o     (count)
  );

  assign out_o.status          = res.status;
  assign out_o.entry_valid     = res.entry_valid;
  assign out_o.peer_high       = res.peer_high;
  assign out_o.peer_low        = res.peer_low;
  assign out_o.upload_flag     = res.upload_flag;
  assign out_o.ipv6_flag       = res.ipv6_flag;
  assign out_o.sum_three       = res.sum_three;
  assign out_o.sum_five        = res.sum_five;
  assign out_o.sum_window      = res.sum_window;
  assign out_o.total_out       = res.total_out;
  assign out_o.peak_out        = res.peak_out;
  assign out_o.entry_count_out = count;
endmodule
`default_nettype wire

[tb/tb_flow_byte_meter_table_top.sv]
// Self-checking testbench of the per-peer byte meter table.
`default_nettype none
module tb_flow_byte_meter_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [fbm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  fbm_in_if in_ch ();
  fbm_out_if out_ch ();

  flow_byte_meter_table_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  typedef struct {
    logic [1:0]  op;
    logic [15:0] eth;
    logic [63:0] sh, sl, dh, dl;
    logic [15:0] len;
    logic [9:0]  idx;
  } pkt_item_t;

  typedef struct {
    logic [2:0]  status;
    logic        ev;
    logic [63:0] ph, pl;
    logic        up, v6;
    logic [31:0] s3, s5, sw, tot, pk;
    logic [10:0] cnt;
  } meter_res_t;

  // predictor state
  logic [31:0] my_v4;
  logic        my_v4_ok;
  logic [63:0] my_v6h, my_v6l;
  logic        my_v6_ok;
  int unsigned n_peers;
  logic [63:0] peer_h [fbm_pkg::ENTRIES];
  logic [63:0] peer_l [fbm_pkg::ENTRIES];
  logic [1:0]  peer_flags [fbm_pkg::ENTRIES];
  int unsigned head_of [fbm_pkg::ENTRIES];
  logic [31:0] slot_bytes [fbm_pkg::ENTRIES][fbm_pkg::SLOTS];
  logic [31:0] tot_bytes [fbm_pkg::ENTRIES];
  logic [31:0] peak_bytes [fbm_pkg::ENTRIES];

  meter_res_t expected_q[$];
  int errors = 0;
  int results_seen = 0;

  // known peers for reuse in random traffic
  logic [63:0] v4_peers[$];
  logic [63:0] v6_peers_h[$];
  logic [63:0] v6_peers_l[$];

  function automatic meter_res_t meter_predict(pkt_item_t it);
    meter_res_t r;
    logic [63:0] sh, sl, dh, dl, ph, pl;
    logic v6, s_self, d_self;
    logic [1:0] fl;
    int unsigned i, h, k;
    r = '{default: '0};
    r.status = fbm_pkg::ST_IGN;
    if (it.op == fbm_pkg::OP_PKT) begin
      sh = it.sh; sl = it.sl; dh = it.dh; dl = it.dl;
      if (it.eth == fbm_pkg::ETH_IPV4 || it.eth == fbm_pkg::ETH_IPV6) begin
        v6 = (it.eth == fbm_pkg::ETH_IPV6);
        if (!v6) begin
          sh = '0; dh = '0; sl[63:32] = '0; dl[63:32] = '0;
          s_self = my_v4_ok && sl[31:0] == my_v4;
          d_self = my_v4_ok && dl[31:0] == my_v4;
        end else begin
          s_self = my_v6_ok && sh == my_v6h && sl == my_v6l;
          d_self = my_v6_ok && dh == my_v6h && dl == my_v6l;
        end
        if (s_self != d_self) begin
          ph = s_self ? dh : sh;
          pl = s_self ? dl : sl;
          fl = {v6, s_self};
          for (i = 0; i < n_peers; i++)
            if (peer_h[i] == ph && peer_l[i] == pl && peer_flags[i] == fl) break;
          if (i < n_peers) begin
            tot_bytes[i] += it.len;
            slot_bytes[i][head_of[i]] += it.len;
            r.status = fbm_pkg::ST_EXIST;
          end else if (n_peers >= fbm_pkg::ENTRIES) begin
            r.status = fbm_pkg::ST_FULL;
          end else begin
            peer_h[i] = ph; peer_l[i] = pl; peer_flags[i] = fl;
            head_of[i] = 0;
            for (k = 0; k < fbm_pkg::SLOTS; k++) slot_bytes[i][k] = '0;
            slot_bytes[i][0] = 32'(it.len);
            tot_bytes[i] = 32'(it.len);
            peak_bytes[i] = '0;
            n_peers++;
            r.status = fbm_pkg::ST_NEW;
          end
        end
      end
    end else if (it.op == fbm_pkg::OP_TICK) begin
      for (i = 0; i < n_peers; i++) begin
        h = head_of[i];
        if (slot_bytes[i][h] > peak_bytes[i]) peak_bytes[i] = slot_bytes[i][h];
        h = (h + 1) % fbm_pkg::SLOTS;
        head_of[i] = h;
        slot_bytes[i][h] = '0;
      end
      r.status = fbm_pkg::ST_TICK;
    end else if (it.op == fbm_pkg::OP_READ) begin
      r.status = fbm_pkg::ST_READ;
      i = 32'(it.idx);
      if (i < n_peers) begin
        r.ev = 1'b1;
        r.ph = peer_h[i]; r.pl = peer_l[i];
        r.up = peer_flags[i][0]; r.v6 = peer_flags[i][1];
        for (k = 1; k <= fbm_pkg::SLOTS; k++) begin
          h = (head_of[i] + fbm_pkg::SLOTS - k) % fbm_pkg::SLOTS;
          if (k <= 3) r.s3 += slot_bytes[i][h];
          if (k <= 5) r.s5 += slot_bytes[i][h];
          r.sw += slot_bytes[i][h];
        end
        r.tot = tot_bytes[i];
        r.pk = peak_bytes[i];
      end
    end
    r.cnt = n_peers[10:0];
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0; in_ch.ethertype = '0;
    in_ch.src_addr_high = '0; in_ch.src_addr_low = '0;
    in_ch.dst_addr_high = '0; in_ch.dst_addr_low = '0;
    in_ch.pkt_len = '0; in_ch.entry_index = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned c;
    c = $urandom_range(0, 99);
    if (c < 45) return 0;
    if (c < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // the block is never ready in the cycle after a transfer, so step past that edge first
  task automatic send_item(pkt_item_t it);
    int unsigned g;
    g = pick_gap();
    repeat (g + 1) @(posedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op; in_ch.ethertype <= it.eth;
    in_ch.src_addr_high <= it.sh; in_ch.src_addr_low <= it.sl;
    in_ch.dst_addr_high <= it.dh; in_ch.dst_addr_low <= it.dl;
    in_ch.pkt_len <= it.len; in_ch.entry_index <= it.idx;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(meter_predict(it));
    in_ch.valid <= 1'b0;
  endtask

  // receiver: random stalls, compare each transfer
  initial begin
    meter_res_t e;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected, status %0d", out_ch.status);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_ch.status); errors++; end
          if (out_ch.entry_valid !== e.ev) begin
            $error("entry_valid exp %0d got %0d", e.ev, out_ch.entry_valid); errors++; end
          if (out_ch.peer_high !== e.ph) begin
            $error("peer_high exp %h got %h", e.ph, out_ch.peer_high); errors++; end
          if (out_ch.peer_low !== e.pl) begin
            $error("peer_low exp %h got %h", e.pl, out_ch.peer_low); errors++; end
          if (out_ch.upload_flag !== e.up) begin
            $error("upload_flag exp %0d got %0d", e.up, out_ch.upload_flag); errors++; end
          if (out_ch.ipv6_flag !== e.v6) begin
            $error("ipv6_flag exp %0d got %0d", e.v6, out_ch.ipv6_flag); errors++; end
          if (out_ch.sum_three !== e.s3) begin
            $error("sum_three exp %0d got %0d", e.s3, out_ch.sum_three); errors++; end
          if (out_ch.sum_five !== e.s5) begin
            $error("sum_five exp %0d got %0d", e.s5, out_ch.sum_five); errors++; end
          if (out_ch.sum_window !== e.sw) begin
            $error("sum_window exp %0d got %0d", e.sw, out_ch.sum_window); errors++; end
          if (out_ch.total_out !== e.tot) begin
            $error("total_out exp %0d got %0d", e.tot, out_ch.total_out); errors++; end
          if (out_ch.peak_out !== e.pk) begin
            $error("peak_out exp %0d got %0d", e.pk, out_ch.peak_out); errors++; end
          if (out_ch.entry_count_out !== e.cnt) begin
            $error("entry_count_out exp %0d got %0d", e.cnt, out_ch.entry_count_out);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 99) < 70) out_ch.ready <= 1'b1;
      else if ($urandom_range(0, 9) == 0) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
    end
  end

  task automatic write_reg(logic [fbm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      fbm_pkg::CFG_V4:       my_v4 = val[31:0];
      fbm_pkg::CFG_V4_VALID: my_v4_ok = val[0];
      fbm_pkg::CFG_V6_HIGH:  my_v6h = val;
      fbm_pkg::CFG_V6_LOW:   my_v6l = val;
      fbm_pkg::CFG_V6_VALID: my_v6_ok = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 2000000) begin
      @(posedge clk_i); guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  function automatic pkt_item_t v4_pkt(logic up, logic [31:0] peer, logic [15:0] len);
    pkt_item_t it;
    it = '{default: '0};
    it.op = fbm_pkg::OP_PKT; it.eth = fbm_pkg::ETH_IPV4; it.len = len;
    it.sh = {$urandom, $urandom}; it.dh = {$urandom, $urandom};
    it.sl = {$urandom, up ? my_v4 : peer};
    it.dl = {$urandom, up ? peer : my_v4};
    it.idx = 10'($urandom);
    return it;
  endfunction

  function automatic pkt_item_t v6_pkt(logic up, logic [63:0] ph, logic [63:0] pl,
                                       logic [15:0] len);
    pkt_item_t it;
    it = '{default: '0};
    it.op = fbm_pkg::OP_PKT; it.eth = fbm_pkg::ETH_IPV6; it.len = len;
    it.sh = up ? my_v6h : ph; it.sl = up ? my_v6l : pl;
    it.dh = up ? ph : my_v6h; it.dl = up ? pl : my_v6l;
    it.idx = 10'($urandom);
    return it;
  endfunction

  function automatic pkt_item_t ctl_item(logic [1:0] op, logic [9:0] idx);
    pkt_item_t it;
    it = '{default: '0};
    it.op = op; it.idx = idx;
    it.eth = 16'($urandom); it.len = 16'($urandom);
    it.sh = {$urandom, $urandom}; it.sl = {$urandom, $urandom};
    it.dh = {$urandom, $urandom}; it.dl = {$urandom, $urandom};
    return it;
  endfunction

  task automatic test_unconfigured();
    // addresses not yet valid: packets ignored, then a read and a tick on an empty table
    send_item(v4_pkt(1'b1, 32'h0a000001, 16'd100));
    send_item(v6_pkt(1'b0, 64'h1, 64'h2, 16'd100));
    send_item(ctl_item(fbm_pkg::OP_READ, 10'd0));
    send_item(ctl_item(fbm_pkg::OP_TICK, 10'd0));
    drain();
  endtask

  task automatic test_directed();
    pkt_item_t it;
    write_reg(fbm_pkg::CFG_V4, 64'hFFFF_FFFF_C0A8_0001);
    write_reg(fbm_pkg::CFG_V4_VALID, 64'h1);
    write_reg(fbm_pkg::CFG_V6_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(fbm_pkg::CFG_V6_LOW, 64'h0000_0000_0000_0001);
    write_reg(fbm_pkg::CFG_V6_VALID, 64'h3);
    write_reg(3'd7, 64'hDEAD_BEEF); // dropped
    send_item(v4_pkt(1'b1, 32'h0808_0808, 16'hFFFF));
    send_item(v4_pkt(1'b1, 32'h0808_0808, 16'hFFFF));
    send_item(v4_pkt(1'b0, 32'h0808_0808, 16'd0));
    send_item(v4_pkt(1'b0, 32'hFFFF_FFFF, 16'd1));
    send_item(v6_pkt(1'b1, 64'h0, 64'h0, 16'd1500));
    send_item(v6_pkt(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd64));
    it = v4_pkt(1'b1, 32'h1, 16'd5); it.dl[31:0] = my_v4; send_item(it); // both local
    it = v4_pkt(1'b1, 32'h1, 16'd5); it.sl[31:0] = 32'h2; send_item(it); // neither
    it = v4_pkt(1'b1, 32'h1, 16'd5); it.eth = 16'h0806; send_item(it);
    it = v4_pkt(1'b1, 32'h1, 16'd5); it.op = 2'd3; send_item(it);
    send_item(ctl_item(fbm_pkg::OP_TICK, 10'd0));
    send_item(v4_pkt(1'b1, 32'h0808_0808, 16'd7));
    send_item(ctl_item(fbm_pkg::OP_TICK, 10'd0));
    for (int k = 0; k < 6; k++) send_item(ctl_item(fbm_pkg::OP_READ, k[9:0]));
    send_item(ctl_item(fbm_pkg::OP_READ, 10'd1023));
    drain();
  endtask

  task automatic test_random(int unsigned count);
    pkt_item_t it;
    int unsigned c, j;
    logic [63:0] a, b;
    for (int n = 0; n < count; n++) begin
      c = $urandom_range(0, 99);
      if (c < 30) begin
        if (v4_peers.size() == 0 || $urandom_range(0, 3) == 0)
          v4_peers.push_back({32'h0, $urandom});
        j = $urandom_range(0, v4_peers.size() - 1);
        it = v4_pkt(1'($urandom_range(0, 1)), v4_peers[j][31:0], 16'($urandom));
      end else if (c < 55) begin
        if (v6_peers_h.size() == 0 || $urandom_range(0, 3) == 0) begin
          v6_peers_h.push_back({$urandom, $urandom});
          v6_peers_l.push_back({$urandom, $urandom});
        end
        j = $urandom_range(0, v6_peers_h.size() - 1);
        a = v6_peers_h[j]; b = v6_peers_l[j];
        it = v6_pkt(1'($urandom_range(0, 1)), a, b, 16'($urandom));
      end else if (c < 67) begin
        it = ctl_item(fbm_pkg::OP_TICK, 10'd0);
      end else if (c < 87) begin
        it = ctl_item(fbm_pkg::OP_READ, $urandom_range(0, 99) < 85 ?
                      10'($urandom_range(0, n_peers + 1)) : 10'($urandom));
      end else begin
        it = ctl_item(2'($urandom_range(0, 3)), 10'($urandom));
        if (it.op == fbm_pkg::OP_TICK || it.op == fbm_pkg::OP_READ) it.op = fbm_pkg::OP_PKT;
        if ($urandom_range(0, 1))
          it.eth = $urandom_range(0, 1) ? fbm_pkg::ETH_IPV4 : fbm_pkg::ETH_IPV6;
      end
      send_item(it);
    end
    drain();
  endtask

  task automatic test_reconfigure();
    // disable v4, move v6 to the other extreme, run traffic, then turn v4 on at zero, v6 off, and run more
    write_reg(fbm_pkg::CFG_V4_VALID, 64'h0);
    write_reg(fbm_pkg::CFG_V6_HIGH, 64'h0);
    write_reg(fbm_pkg::CFG_V6_LOW, 64'h0);
    test_random(120);
    write_reg(fbm_pkg::CFG_V4, 64'h0);
    write_reg(fbm_pkg::CFG_V4_VALID, 64'h1);
    write_reg(fbm_pkg::CFG_V6_VALID, 64'h0);
    test_random(120);
  endtask

  initial begin
    my_v4 = '0; my_v4_ok = 1'b0; my_v6h = '0; my_v6l = '0; my_v6_ok = 1'b0;
    n_peers = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unconfigured();
    test_directed();
    test_random(310);
    test_reconfigure();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(200ms);
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
hdl/fbm_pkg.sv
hdl/fbm_if.sv
hdl/fbm_classify.sv
hdl/fbm_engine.sv
hdl/flow_byte_meter_table_top.sv
tb/tb_flow_byte_meter_table_top.sv
